FILE: hdl/zse_pkg.sv
package zse_pkg;

  // Position counter width; reported positions are cut or extended to 32 bits
  localparam int POS_W = 32;

  localparam logic [31:0] SIG_LOCAL      = 32'h0403_4b50;
  localparam logic [31:0] SIG_EOCD       = 32'h0605_4b50;
  localparam logic [31:0] SIG_CENTRAL    = 32'h0201_4b50;
  localparam logic [31:0] SIG_DESCRIPTOR = 32'h0807_4b50;

  localparam int FLAG_DESC_BIT = 3;
  localparam int FLAG_UTF8_BIT = 11;

  localparam logic [31:0] HDR_BYTES  = 32'd30;
  localparam logic [31:0] DESC_BYTES = 32'd16;

  // Width of the packed result payload, rounded up to whole bytes
  localparam int OUT_DATA_W = 136;

  typedef enum logic [2:0] {
    KIND_ENTRY      = 3'd0,
    KIND_CDIR       = 3'd1,
    KIND_END        = 3'd2,
    KIND_BAD_SIG    = 3'd3,
    KIND_BAD_METHOD = 3'd4,
    KIND_NO_DESC    = 3'd5,
    KIND_TRUNC      = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] data_start;
    logic [31:0] data_size;
    logic [31:0] name_offset;
    logic [15:0] name_length;
    logic        name_is_utf8;
    logic        via_descriptor;
    logic [15:0] method_seen;
    logic        last_of_run;
  } result_t;

  // Up to two results caused by one byte, in delivery order
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

endpackage

FILE: hdl/zip_stored_entry_splitter.sv
// Walks a ZIP archive fed one byte per word and reports each stored entry.
//
// Input channel: in_tdata[7:0] carries the next archive byte, in_tlast marks
// the final byte of the file. Output channel: one word per result, with the
// result kind on out_tuser and out_tlast set on the last result that a given
// input byte caused.
//
// Each byte is parsed in the cycle it is accepted; its results enter a
// three-word output queue and raise out_tvalid in the next cycle. One byte
// per cycle is sustained while results are taken; a byte that causes two
// results (only the last byte of a file) keeps in_tready low until two words
// are free. in_tready follows only queue fill, never out_tready directly.
//
// Reset clears the parse state and empties the queue. When the receiver
// stalls, results wait in the queue and in_tready drops once fewer than two
// free words remain. After the final byte every counter returns to its
// reset value, so the next byte begins a new file.
module zip_stored_entry_splitter
  import zse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // data_byte
  input  logic                  in_tlast,   // end_of_file
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // data_start, data_size, name_offset, name_length, name_is_utf8,
  // via_descriptor, method_seen, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [2:0]            out_tuser,  // kind
  output logic                  out_tlast   // last_of_run
);

  logic         accept;
  result_pair_t res;
  result_t      head;

  assign accept = in_tvalid && in_tready;

  zse_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .byte_i   (in_tdata),
    .last_i   (in_tlast),
    .res_o    (res)
  );

  zse_out_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (res),
    .ready_o     (in_tready),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .head_o      (head)
  );

  // Pack the head result onto the output word
  assign out_tdata = {6'd0,
                      head.method_seen,
                      head.via_descriptor,
                      head.name_is_utf8,
                      head.name_length,
                      head.name_offset,
                      head.data_size,
                      head.data_start};
  assign out_tuser = head.kind;
  assign out_tlast = head.last_of_run;

endmodule

FILE: hdl/zse_parser.sv
module zse_parser
  import zse_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         accept_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  output result_pair_t res_o
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_NAME   = 3'd1,
    PH_EXTRA  = 3'd2,
    PH_DATA   = 3'd3,
    PH_SCAN   = 3'd4,
    PH_DESC   = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [31:0]        cnt_r, cnt_nxt;
  logic [15:0]        flags_r, flags_nxt;
  logic [15:0]        method_r, method_nxt;
  logic [15:0]        name_len_r, name_len_nxt;
  logic [15:0]        extra_len_r, extra_len_nxt;
  logic [31:0]        size_r, size_nxt;
  logic [31:0]        sig_r, sig_nxt;
  logic [POS_W-1:0]   entry_start_r, entry_start_nxt;
  logic [POS_W-1:0]   name_start_r, name_start_nxt;

  result_t            res_a;
  result_t            res_e;
  logic               a_v;
  logic               e_v;
  logic               fin;
  logic               ent_v;
  logic               ent_via;
  logic [31:0]        cnt_inc;

  // Advance the parse by one byte and collect the results it causes
  always_comb begin
    phase_nxt       = phase_r;
    pos_nxt         = (pos_r != POS_MAX) ? pos_r + POS_W'(1) : pos_r;
    cnt_nxt         = cnt_r;
    flags_nxt       = flags_r;
    method_nxt      = method_r;
    name_len_nxt    = name_len_r;
    extra_len_nxt   = extra_len_r;
    size_nxt        = size_r;
    sig_nxt         = sig_r;
    entry_start_nxt = entry_start_r;
    name_start_nxt  = name_start_r;
    res_a           = '0;
    res_e           = '0;
    a_v             = 1'b0;
    e_v             = 1'b0;
    fin             = 1'b0;
    ent_v           = 1'b0;
    ent_via         = 1'b0;
    cnt_inc         = cnt_r + 32'd1;

    unique case (phase_r)
      PH_HEADER: begin
        // Clear captured fields at the start of each header
        if (cnt_r == 32'd0) begin
          flags_nxt       = '0;
          method_nxt      = '0;
          name_len_nxt    = '0;
          extra_len_nxt   = '0;
          size_nxt        = '0;
          sig_nxt         = '0;
          entry_start_nxt = pos_r;
        end
        if (cnt_r < 32'd4)   sig_nxt = {byte_i, sig_nxt[31:8]};
        if (cnt_r == 32'd6)  flags_nxt[7:0]      = byte_i;
        if (cnt_r == 32'd7)  flags_nxt[15:8]     = byte_i;
        if (cnt_r == 32'd8)  method_nxt[7:0]     = byte_i;
        if (cnt_r == 32'd9)  method_nxt[15:8]    = byte_i;
        if (cnt_r == 32'd22) size_nxt[7:0]       = byte_i;
        if (cnt_r == 32'd23) size_nxt[15:8]      = byte_i;
        if (cnt_r == 32'd24) size_nxt[23:16]     = byte_i;
        if (cnt_r == 32'd25) size_nxt[31:24]     = byte_i;
        if (cnt_r == 32'd26) name_len_nxt[7:0]   = byte_i;
        if (cnt_r == 32'd27) name_len_nxt[15:8]  = byte_i;
        if (cnt_r == 32'd28) extra_len_nxt[7:0]  = byte_i;
        if (cnt_r == 32'd29) extra_len_nxt[15:8] = byte_i;
        cnt_nxt = cnt_inc;
        // Classify the header once all of it is in
        if (cnt_inc == HDR_BYTES) begin
          cnt_nxt = '0;
          if (sig_nxt == SIG_CENTRAL || sig_nxt == SIG_EOCD) begin
            a_v              = 1'b1;
            res_a.kind       = KIND_CDIR;
            res_a.data_start = 32'(entry_start_nxt);
            phase_nxt        = PH_DONE;
          end else if (sig_nxt != SIG_LOCAL) begin
            a_v              = 1'b1;
            res_a.kind       = KIND_BAD_SIG;
            res_a.data_start = 32'(entry_start_nxt);
            phase_nxt        = PH_DONE;
          end else begin
            name_start_nxt = pos_nxt;
            if (name_len_nxt != 16'd0)       phase_nxt = PH_NAME;
            else if (extra_len_nxt != 16'd0) phase_nxt = PH_EXTRA;
            else                             fin = 1'b1;
          end
        end
      end
      PH_NAME: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= {16'd0, name_len_r}) begin
          cnt_nxt = '0;
          if (extra_len_r != 16'd0) phase_nxt = PH_EXTRA;
          else                      fin = 1'b1;
        end
      end
      PH_EXTRA: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= {16'd0, extra_len_r}) begin
          cnt_nxt = '0;
          fin     = 1'b1;
        end
      end
      PH_DATA: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= size_r) begin
          cnt_nxt   = '0;
          phase_nxt = PH_HEADER;
        end
      end
      PH_SCAN: begin
        // Slide the window until the descriptor signature shows up
        sig_nxt = {byte_i, sig_r[31:8]};
        if (cnt_r < 32'd4) cnt_nxt = cnt_inc;
        if (cnt_nxt >= 32'd4 && sig_nxt == SIG_DESCRIPTOR) begin
          cnt_nxt   = '0;
          size_nxt  = '0;
          phase_nxt = PH_DESC;
        end
      end
      PH_DESC: begin
        if (cnt_r == 32'd4) size_nxt[7:0]   = byte_i;
        if (cnt_r == 32'd5) size_nxt[15:8]  = byte_i;
        if (cnt_r == 32'd6) size_nxt[23:16] = byte_i;
        if (cnt_r == 32'd7) size_nxt[31:24] = byte_i;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= DESC_BYTES - 32'd4) begin
          cnt_nxt   = '0;
          ent_v     = 1'b1;
          ent_via   = 1'b1;
          phase_nxt = PH_HEADER;
        end
      end
      default: phase_nxt = PH_DONE;
    endcase

    // Name and extra are behind us: check the method, then start the data
    if (fin) begin
      if (method_nxt != 16'd0) begin
        a_v               = 1'b1;
        res_a.kind        = KIND_BAD_METHOD;
        res_a.method_seen = method_nxt;
        phase_nxt         = PH_DONE;
      end else begin
        entry_start_nxt = pos_nxt;
        cnt_nxt         = '0;
        if (flags_nxt[FLAG_DESC_BIT]) begin
          sig_nxt   = '0;
          phase_nxt = PH_SCAN;
        end else begin
          ent_v     = 1'b1;
          phase_nxt = (size_nxt == 32'd0) ? PH_HEADER : PH_DATA;
        end
      end
    end

    if (ent_v) begin
      a_v                  = 1'b1;
      res_a.kind           = KIND_ENTRY;
      res_a.data_start     = 32'(entry_start_nxt);
      res_a.data_size      = size_nxt;
      res_a.name_offset    = 32'(name_start_nxt);
      res_a.name_length    = name_len_nxt;
      res_a.name_is_utf8   = flags_nxt[FLAG_UTF8_BIT];
      res_a.via_descriptor = ent_via;
      res_a.method_seen    = method_nxt;
    end

    // End of file: report where it left us unless parsing had stopped, then return to reset state
    if (last_i) begin
      unique case (phase_nxt)
        PH_HEADER, PH_DATA: begin
          e_v        = 1'b1;
          res_e.kind = KIND_END;
        end
        PH_NAME, PH_EXTRA: begin
          e_v        = 1'b1;
          res_e.kind = KIND_TRUNC;
        end
        PH_SCAN, PH_DESC: begin
          e_v        = 1'b1;
          res_e.kind = KIND_NO_DESC;
        end
        default: e_v = 1'b0;
      endcase
      phase_nxt       = PH_HEADER;
      pos_nxt         = '0;
      cnt_nxt         = '0;
      flags_nxt       = '0;
      method_nxt      = '0;
      name_len_nxt    = '0;
      extra_len_nxt   = '0;
      size_nxt        = '0;
      sig_nxt         = '0;
      entry_start_nxt = '0;
      name_start_nxt  = '0;
    end

    // Order the results and mark the last one
    res_e.last_of_run = 1'b1;
    res_a.last_of_run = !e_v;
    res_o.count  = 2'({1'b0, a_v} + {1'b0, e_v});
    res_o.first  = a_v ? res_a : res_e;
    res_o.second = res_e;
    if (!accept_i) res_o.count = 2'd0;
  end

  // Hold parse state; update on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      pos_r         <= '0;
      cnt_r         <= '0;
      flags_r       <= '0;
      method_r      <= '0;
      name_len_r    <= '0;
      extra_len_r   <= '0;
      size_r        <= '0;
      sig_r         <= '0;
      entry_start_r <= '0;
      name_start_r  <= '0;
    end else if (accept_i) begin
      phase_r       <= phase_nxt;
      pos_r         <= pos_nxt;
      cnt_r         <= cnt_nxt;
      flags_r       <= flags_nxt;
      method_r      <= method_nxt;
      name_len_r    <= name_len_nxt;
      extra_len_r   <= extra_len_nxt;
      size_r        <= size_nxt;
      sig_r         <= sig_nxt;
      entry_start_r <= entry_start_nxt;
      name_start_r  <= name_start_nxt;
    end
  end

`ifndef SYNTHESIS
  a_eof_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept_i && last_i |=> phase_r == PH_HEADER && pos_r == '0 && cnt_r == '0)
    else $error("parser did not restart after final byte");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept_i && phase_r == PH_DONE |-> res_o.count == 2'd0)
    else $error("result produced after parsing stopped");

  a_two_only_at_eof: assert property (@(posedge clk) disable iff (!rst_n)
    res_o.count == 2'd2 |-> last_i && res_o.second.kind != KIND_ENTRY)
    else $error("two results without end of file");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_o.count != 2'd3)
    else $error("more than two results for one byte");
`endif

endmodule

FILE: hdl/zse_out_queue.sv
module zse_out_queue
  import zse_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  result_pair_t push_i,
  output logic         ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output result_t      head_o
);

  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] base;
  logic       pop;
  result_t    q_r   [3];
  result_t    q_nxt [3];

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_r != 2'd0);
  assign head_o      = q_r[0];
  // Room for the two results one byte can cause
  assign ready_o     = (cnt_r <= 2'd1);

  // Shift out the head, then append new results behind the survivors
  always_comb begin
    base = cnt_r - {1'b0, pop};
    for (int i = 0; i < 2; i++) begin
      q_nxt[i] = pop ? q_r[i+1] : q_r[i];
    end
    q_nxt[2] = q_r[2];
    for (int i = 0; i < 3; i++) begin
      if (push_i.count != 2'd0 && 2'(i) == base) q_nxt[i] = push_i.first;
      if (push_i.count == 2'd2 && 2'(i) == base + 2'd1) q_nxt[i] = push_i.second;
    end
    cnt_nxt = base + push_i.count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i.count != 2'd0 |-> cnt_r <= 2'd1)
    else $error("result queue written without room");
`endif

endmodule

FILE: dv/testbench.sv
module testbench;
  import zse_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 550;
  localparam int QUIET_TAIL   = 200;
  localparam int PRINT_CAP    = 40;

  // Parser phases, as the block walks one archive
  typedef enum logic [2:0] {
    PH_HEADER, PH_NAME, PH_EXTRA, PH_DATA, PH_SCAN, PH_DESC, PH_DONE
  } parse_phase_t;

  // What a directed archive carries after its first header and fill
  typedef enum logic [1:0] {TAIL_NONE, TAIL_DESC, TAIL_FALSE_DESC, TAIL_CDIR} tail_t;

  typedef struct packed {
    logic [31:0] sig;
    logic [15:0] flags;
    logic [15:0] method;
    logic [31:0] size;
    logic [15:0] nlen;
    logic [15:0] xlen;
    int          fill;
    tail_t       tail;
    int          cut;
    kind_t       want;
  } archive_row_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       hold;
    logic       has_want;
    kind_t      want;
  } archive_byte_t;

  typedef struct {
    kind_t       kind;
    logic [31:0] doff;
    logic [31:0] size;
    logic [31:0] noff;
    logic [15:0] nlen;
    logic        utf8;
    logic        viad;
    logic [15:0] meth;
    logic        last;
    logic        typed;
    kind_t       want;
  } zip_result_t;

  // Directed archives, one file each; want is the kind of the first result
  localparam archive_row_t DIRECTED [20] = '{
    // short tail: one byte of a header
    '{32'h0, 16'h0, 16'h0, 32'd0, 16'd0, 16'd0, 0, TAIL_NONE, 1, KIND_END},
    // file ends in the middle of a header
    '{SIG_LOCAL, 16'h0, 16'h0, 32'd0, 16'd0, 16'd0, 0, TAIL_NONE, 17, KIND_END},
    // stored entry, end inside data
    '{SIG_LOCAL, 16'h0800, 16'h0, 32'd3, 16'd2, 16'd1, 5, TAIL_NONE, -1, KIND_ENTRY},
    // empty entry followed by the central directory
    '{SIG_LOCAL, 16'h0, 16'h0, 32'd0, 16'd0, 16'd0, 0, TAIL_CDIR, -1, KIND_ENTRY},
    '{SIG_EOCD, 16'h0, 16'h0, 32'd0, 16'd0, 16'd0, 0, TAIL_NONE, -1, KIND_CDIR},
    // bytes after a stop are ignored
    '{SIG_CENTRAL, 16'h0, 16'h0, 32'd0, 16'd0, 16'd0, 4, TAIL_NONE, -1, KIND_CDIR},
    '{32'h0403_4b51, 16'h0, 16'h0, 32'd0, 16'd0, 16'd0, 0, TAIL_NONE, -1, KIND_BAD_SIG},
    '{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 0, TAIL_NONE,
      -1, KIND_BAD_SIG},
    '{SIG_LOCAL, 16'h0, 16'd8, 32'd0, 16'd1, 16'd0, 4, TAIL_NONE, -1, KIND_BAD_METHOD},
    '{SIG_LOCAL, 16'h0, 16'hFFFF, 32'd0, 16'd0, 16'd0, 0, TAIL_NONE, -1, KIND_BAD_METHOD},
    // truncation wins over a bad method
    '{SIG_LOCAL, 16'h0, 16'd8, 32'd0, 16'd5, 16'd0, 2, TAIL_NONE, -1, KIND_TRUNC},
    '{SIG_LOCAL, 16'h0, 16'h0, 32'd0, 16'hFFFF, 16'd0, 3, TAIL_NONE, -1, KIND_TRUNC},
    '{SIG_LOCAL, 16'h0, 16'h0, 32'd0, 16'd0, 16'hFFFF, 5, TAIL_NONE, -1, KIND_TRUNC},
    '{SIG_LOCAL, 16'hF7F7, 16'h0, 32'hFFFF_FFFF, 16'd1, 16'd1, 6, TAIL_NONE, -1, KIND_ENTRY},
    // entry and end of data from the header's final byte
    '{SIG_LOCAL, 16'h0, 16'h0, 32'd5, 16'd0, 16'd0, 0, TAIL_NONE, -1, KIND_ENTRY},
    // descriptor entry, entry and end of data from the last descriptor byte
    '{SIG_LOCAL, 16'h0808, 16'h0, 32'hDEAD_BEEF, 16'd3, 16'd2, 12, TAIL_DESC, -1, KIND_ENTRY},
    '{SIG_LOCAL, 16'hFFFF, 16'h0, 32'd0, 16'd0, 16'd0, 0, TAIL_DESC, -1, KIND_ENTRY},
    // descriptor missing, then descriptor cut short
    '{SIG_LOCAL, 16'h0008, 16'h0, 32'd0, 16'd0, 16'd0, 9, TAIL_NONE, -1, KIND_NO_DESC},
    '{SIG_LOCAL, 16'h0008, 16'h0, 32'd7, 16'd0, 16'd0, 2, TAIL_DESC, 41, KIND_NO_DESC},
    // partial signature just ahead of the real one
    '{SIG_LOCAL, 16'h0008, 16'h0, 32'h12, 16'd1, 16'd0, 2, TAIL_FALSE_DESC, -1, KIND_ENTRY}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;
  logic                  out_tlast;

  archive_byte_t archive_q[$];
  zip_result_t   pending_results[$];
  zip_result_t   step_buf[$];

  int mismatch_count  = 0;
  int cycle_count     = 0;
  int accept_idx      = 0;
  int files_built     = 0;
  int results_checked = 0;
  int entries_seen    = 0;
  int desc_entries    = 0;
  bit quiet           = 0;
  bit want_armed      = 0;
  kind_t want_kind    = KIND_ENTRY;

  // Parser copy
  parse_phase_t      p_phase;
  logic [POS_W-1:0]  p_pos;
  logic [31:0]       p_cnt;
  logic [15:0]       p_flags;
  logic [15:0]       p_method;
  logic [15:0]       p_nlen;
  logic [15:0]       p_xlen;
  logic [31:0]       p_size;
  logic [31:0]       p_sig;
  logic [POS_W-1:0]  p_entry_start;
  logic [POS_W-1:0]  p_name_start;

  zip_stored_entry_splitter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------- archive building

  task automatic put_byte(input logic [7:0] b);
    archive_byte_t w;
    w.data = b;
    w.last = 1'b0;
    w.hold = 1'b0;
    w.has_want = 1'b0;
    w.want = KIND_ENTRY;
    archive_q.push_back(w);
  endtask

  task automatic put_le(input logic [31:0] v, input int n);
    for (int k = 0; k < n; k++) put_byte(v[8*k +: 8]);
  endtask

  task automatic put_fill(input int n);
    for (int k = 0; k < n; k++) put_byte(8'($urandom));
  endtask

  // Local header layout: sizes at 18 and 22, the parsed one at 22
  task automatic put_header(input logic [31:0] sig, input logic [15:0] flags, method,
                            input logic [31:0] size, input logic [15:0] nlen, xlen);
    put_le(sig, 4);
    put_le($urandom, 2);
    put_le(flags, 2);
    put_le(method, 2);
    put_le($urandom, 4);
    put_le($urandom, 4);
    put_le($urandom, 4);
    put_le(size, 4);
    put_le(nlen, 2);
    put_le(xlen, 2);
  endtask

  task automatic put_desc(input logic [31:0] size);
    put_le(SIG_DESCRIPTOR, 4);
    put_le($urandom, 4);
    put_le(size, 4);
    put_le($urandom, 4);
  endtask

  // Drop bytes beyond a cut point and mark the final byte
  task automatic close_file(input int start, input int cut);
    while (archive_q.size() > start + cut) void'(archive_q.pop_back());
    archive_q[archive_q.size()-1].last = 1'b1;
    files_built++;
  endtask

  // Random archive: mostly well-formed entry chains, some noise and cut files
  task automatic gen_file(input logic hold);
    int start, n_ent, len;
    logic desc;
    logic [15:0] flags, method, nlen, xlen;
    logic [31:0] size, sig;
    start = archive_q.size();
    if ($urandom_range(0, 9) == 0) begin
      put_fill($urandom_range(1, 40));
    end else begin
      n_ent = $urandom_range(1, 3);
      for (int e = 0; e < n_ent; e++) begin
        sig    = ($urandom_range(0, 29) == 0) ? $urandom : SIG_LOCAL;
        desc   = ($urandom_range(0, 3) == 0);
        flags  = (16'($urandom) & ~16'h0008) | {12'h0, desc, 3'b000};
        method = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0;
        nlen   = 16'($urandom_range(0, 6));
        xlen   = 16'($urandom_range(0, 4));
        size   = ($urandom_range(0, 24) == 0) ? $urandom : 32'($urandom_range(0, 12));
        put_header(sig, flags, method, size, nlen, xlen);
        put_fill(int'(nlen) + int'(xlen));
        if (desc) begin
          put_fill($urandom_range(0, 8));
          if ($urandom_range(0, 7) != 0) put_desc($urandom);
        end else begin
          put_fill((size > 12) ? $urandom_range(0, 12) : int'(size));
        end
      end
      case ($urandom_range(0, 3))
        0: begin
          put_header(SIG_CENTRAL, $urandom, $urandom, $urandom, $urandom, $urandom);
          put_fill($urandom_range(0, 4));
        end
        1: put_header(SIG_EOCD, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: ;
      endcase
    end
    len = archive_q.size() - start;
    if ($urandom_range(0, 3) == 0) len = $urandom_range(1, len);
    archive_q[start].hold = hold;
    close_file(start, len);
  endtask

  // ---------------------------------------------------------------- parser prediction

  task automatic reset_parser();
    p_phase = PH_HEADER;
    p_pos = '0;
    p_cnt = '0;
    p_flags = '0;
    p_method = '0;
    p_nlen = '0;
    p_xlen = '0;
    p_size = '0;
    p_sig = '0;
    p_entry_start = '0;
    p_name_start = '0;
  endtask

  task automatic emit(input kind_t k, input logic [31:0] doff, sz, noff,
                      input logic [15:0] nl, input logic u8, vd, input logic [15:0] mt);
    zip_result_t r;
    r.kind = k;
    r.doff = doff;
    r.size = sz;
    r.noff = noff;
    r.nlen = nl;
    r.utf8 = u8;
    r.viad = vd;
    r.meth = mt;
    r.last = 1'b0;
    r.typed = want_armed;
    r.want = want_kind;
    want_armed = 1'b0;
    step_buf.push_back(r);
  endtask

  task automatic emit_entry(input logic vd);
    emit(KIND_ENTRY, 32'(p_entry_start), p_size, 32'(p_name_start), p_nlen,
         p_flags[FLAG_UTF8_BIT], vd, p_method);
  endtask

  // Name and extra are done: check the method, then report or start scanning
  task automatic finish_fields();
    if (p_method != 16'h0) begin
      emit(KIND_BAD_METHOD, 0, 0, 0, 0, 0, 0, p_method);
      p_phase = PH_DONE;
    end else begin
      p_entry_start = p_pos;
      p_cnt = '0;
      if (p_flags[FLAG_DESC_BIT]) begin
        p_sig = '0;
        p_phase = PH_SCAN;
      end else begin
        emit_entry(1'b0);
        p_phase = (p_size == 32'h0) ? PH_HEADER : PH_DATA;
      end
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eof);
    logic [POS_W-1:0] idx;
    logic [31:0] c;
    idx = p_pos;
    if (p_pos != '1) p_pos = p_pos + POS_W'(1);
    c = p_cnt;
    case (p_phase)
      PH_HEADER: begin
        if (c == 0) begin
          p_flags = '0;
          p_method = '0;
          p_nlen = '0;
          p_xlen = '0;
          p_size = '0;
          p_sig = '0;
          p_entry_start = idx;
        end
        if (c < 4) p_sig = {b, p_sig[31:8]};
        else if (c == 6 || c == 7) p_flags[(c-6)*8 +: 8] = b;
        else if (c == 8 || c == 9) p_method[(c-8)*8 +: 8] = b;
        else if (c >= 22 && c <= 25) p_size[(c-22)*8 +: 8] = b;
        else if (c == 26 || c == 27) p_nlen[(c-26)*8 +: 8] = b;
        else if (c == 28 || c == 29) p_xlen[(c-28)*8 +: 8] = b;
        p_cnt = c + 1;
        if (p_cnt == HDR_BYTES) begin
          p_cnt = '0;
          if (p_sig == SIG_CENTRAL || p_sig == SIG_EOCD) begin
            emit(KIND_CDIR, 32'(p_entry_start), 0, 0, 0, 0, 0, 0);
            p_phase = PH_DONE;
          end else if (p_sig != SIG_LOCAL) begin
            emit(KIND_BAD_SIG, 32'(p_entry_start), 0, 0, 0, 0, 0, 0);
            p_phase = PH_DONE;
          end else begin
            p_name_start = p_pos;
            if (p_nlen != 0) p_phase = PH_NAME;
            else if (p_xlen != 0) p_phase = PH_EXTRA;
            else finish_fields();
          end
        end
      end
      PH_NAME: begin
        p_cnt = c + 1;
        if (p_cnt >= 32'(p_nlen)) begin
          p_cnt = '0;
          if (p_xlen != 0) p_phase = PH_EXTRA;
          else finish_fields();
        end
      end
      PH_EXTRA: begin
        p_cnt = c + 1;
        if (p_cnt >= 32'(p_xlen)) begin
          p_cnt = '0;
          finish_fields();
        end
      end
      PH_DATA: begin
        p_cnt = c + 1;
        if (p_cnt >= p_size) begin
          p_cnt = '0;
          p_phase = PH_HEADER;
        end
      end
      // Linear scan: the window only counts once four bytes are in
      PH_SCAN: begin
        p_sig = {b, p_sig[31:8]};
        if (p_cnt < 4) p_cnt = p_cnt + 1;
        if (p_cnt >= 4 && p_sig == SIG_DESCRIPTOR) begin
          p_cnt = '0;
          p_size = '0;
          p_phase = PH_DESC;
        end
      end
      PH_DESC: begin
        if (c >= 4 && c <= 7) p_size[(c-4)*8 +: 8] = b;
        p_cnt = c + 1;
        if (p_cnt >= DESC_BYTES - 4) begin
          p_cnt = '0;
          emit_entry(1'b1);
          p_phase = PH_HEADER;
        end
      end
      default: p_phase = PH_DONE;
    endcase

    // Final byte: report what the file ended in unless parsing had stopped, then start over
    if (eof) begin
      case (p_phase)
        PH_HEADER, PH_DATA: emit(KIND_END, 0, 0, 0, 0, 0, 0, 0);
        PH_NAME, PH_EXTRA:  emit(KIND_TRUNC, 0, 0, 0, 0, 0, 0, 0);
        PH_SCAN, PH_DESC:   emit(KIND_NO_DESC, 0, 0, 0, 0, 0, 0, 0);
        default: ;
      endcase
      reset_parser();
    end

    if (step_buf.size() > 0) step_buf[step_buf.size()-1].last = 1'b1;
    foreach (step_buf[k]) pending_results.push_back(step_buf[k]);
    step_buf.delete();
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic check_result();
    zip_result_t w;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result word with nothing expected, kind %0d", out_tuser));
      return;
    end
    w = pending_results.pop_front();
    results_checked++;
    if (w.kind == KIND_ENTRY) entries_seen++;
    if (w.kind == KIND_ENTRY && w.viad) desc_entries++;
    check_field("kind", 32'(out_tuser), 32'(w.kind));
    check_field("data_start", out_tdata[31:0], w.doff);
    check_field("data_size", out_tdata[63:32], w.size);
    check_field("name_offset", out_tdata[95:64], w.noff);
    check_field("name_length", 32'(out_tdata[111:96]), 32'(w.nlen));
    check_field("name_is_utf8", 32'(out_tdata[112]), 32'(w.utf8));
    check_field("via_descriptor", 32'(out_tdata[113]), 32'(w.viad));
    check_field("method_seen", 32'(out_tdata[129:114]), 32'(w.meth));
    check_field("zero fill", 32'(out_tdata[OUT_DATA_W-1:130]), 32'h0);
    check_field("last_of_run", 32'(out_tlast), 32'(w.last));
    if (w.typed) check_field("first kind of file", 32'(out_tuser), 32'(w.want));
  endtask

  // Predict on each accepted byte, then check each accepted result word
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      if (archive_q[accept_idx].has_want) begin
        want_armed = 1'b1;
        want_kind = archive_q[accept_idx].want;
      end
      accept_idx++;
      parse_byte(in_tdata, in_tlast);
    end
    if (rst_n && out_tvalid && out_tready) check_result();
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stall bursts, none near the end
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    int start, dir_files, gap;
    bit mid_hold;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h0;
    in_tlast = 1'b0;
    mid_hold = 1'b0;
    reset_parser();

    // Walk the directed table, one file per row
    foreach (DIRECTED[r]) begin
      start = archive_q.size();
      put_header(DIRECTED[r].sig, DIRECTED[r].flags, DIRECTED[r].method, DIRECTED[r].size,
                 DIRECTED[r].nlen, DIRECTED[r].xlen);
      put_fill(DIRECTED[r].fill);
      case (DIRECTED[r].tail)
        TAIL_DESC: put_desc(DIRECTED[r].size);
        TAIL_FALSE_DESC: begin
          put_byte(8'h50);
          put_byte(8'h4b);
          put_byte(8'h07);
          put_desc(DIRECTED[r].size);
        end
        TAIL_CDIR: put_header(SIG_CENTRAL, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: ;
      endcase
      archive_q[start].has_want = 1'b1;
      archive_q[start].want = DIRECTED[r].want;
      close_file(start, (DIRECTED[r].cut >= 0) ? DIRECTED[r].cut : archive_q.size() - start);
    end
    dir_files = files_built;

    // Random archives; drain the results before the first and a middle one
    start = archive_q.size();
    gen_file(1'b1);
    while (archive_q.size() - start < RANDOM_BYTES) begin
      if (!mid_hold && archive_q.size() - start >= RANDOM_BYTES / 2) begin
        mid_hold = 1'b1;
        gen_file(1'b1);
      end else begin
        gen_file(1'b0);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Send every byte, idling in random bursts except near the end
    for (int i = 0; i < archive_q.size(); i++) begin
      @(negedge clk);
      if (i >= archive_q.size() - QUIET_TAIL) quiet = 1'b1;
      gap = (!quiet && $urandom_range(0, 9) == 0) ? $urandom_range(1, 18) : 0;
      if (gap != 0 || archive_q[i].hold) begin
        in_tvalid <= 1'b0;
        repeat ((gap != 0) ? gap : 1) @(negedge clk);
        while (archive_q[i].hold && pending_results.size() != 0) @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= archive_q[i].data;
      in_tlast <= archive_q[i].last;
      do @(posedge clk); while (!in_tready);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain, then watch for stray words
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("fed %0d bytes in %0d archives (%0d directed), checked %0d result words",
             archive_q.size(), files_built, dir_files, results_checked);
    $display("entries reported: %0d, of them sized by a data descriptor: %0d",
             entries_seen, desc_entries);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
